### hw/rtl/sobel_pkg.sv
// Shared types and constants for the RGB Sobel edge magnitude unit.
package sobel_pkg;

  localparam int CHAN_W         = 8;
  localparam int PIX_W          = 3 * CHAN_W;
  localparam int CFG_W          = 12;
  localparam int CFG_AW         = 1;
  localparam int COORD_W        = 11;
  localparam int EDGE_W         = 8;
  localparam int GRAD_W         = 11;
  localparam int RES_W          = EDGE_W + 2 * COORD_W;
  localparam int OUT_W          = 32;
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int RESET_WIDTH    = 1280;
  localparam int RESET_HEIGHT   = 720;
  localparam int MIN_SIZE       = 3;
  localparam int FIFO_DEPTH     = 8;
  localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW        = $clog2(FIFO_DEPTH + 1);

  localparam logic [EDGE_W-1:0] EDGE_MAX = 8'd255;

  typedef enum logic [CFG_AW-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } sobel_cfg_idx_t;

  typedef struct packed {
    logic               emit;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } sobel_meta_t;

  typedef struct packed {
    logic               valid;
    logic [EDGE_W-1:0]  edge_value;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } sobel_res_t;

endpackage

### hw/rtl/sobel_ram.sv
// Generic single-port-write, registered-read RAM.
module sobel_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sobel_kernel.sv
// Per-channel Sobel gradients over the 3x3 window and weighted channel combination.
module sobel_kernel
  import sobel_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [8:0][PIX_W-1:0] window,
  input  sobel_meta_t           meta,
  output sobel_res_t            res
);

  function automatic logic [9:0] abs_diff(input logic [9:0] a, input logic [9:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [GRAD_W-1:0] chan_grad(input logic [8:0][CHAN_W-1:0] p);
    logic [9:0] xp;
    logic [9:0] xn;
    logic [9:0] yp;
    logic [9:0] yn;
    xp = 10'(p[2]) + 10'({p[5], 1'b0}) + 10'(p[8]);
    xn = 10'(p[0]) + 10'({p[3], 1'b0}) + 10'(p[6]);
    yp = 10'(p[0]) + 10'({p[1], 1'b0}) + 10'(p[2]);
    yn = 10'(p[6]) + 10'({p[7], 1'b0}) + 10'(p[8]);
    return GRAD_W'(abs_diff(xp, xn)) + GRAD_W'(abs_diff(yp, yn));
  endfunction

  logic [2:0][GRAD_W-1:0] grad;
  logic [2:0][GRAD_W-1:0] grad_r;
  sobel_meta_t            meta_r;
  logic                   vld_r;
  logic [GRAD_W+1:0]      sum;
  logic [GRAD_W-1:0]      quot;

  always_comb begin
    logic [8:0][CHAN_W-1:0] p;
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        p[k] = window[k][CHAN_W*ch +: CHAN_W];
      end
      grad[ch] = chan_grad(p);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_valid;
    end
    grad_r <= grad;
    meta_r <= meta;
  end

  assign sum  = (GRAD_W+2)'({grad_r[0], 1'b0}) + (GRAD_W+2)'(grad_r[1])
              + (GRAD_W+2)'(grad_r[2]);
  assign quot = sum[GRAD_W+1:2];

  always_comb begin
    res.valid      = vld_r;
    res.edge_value = (quot > GRAD_W'(EDGE_MAX)) ? EDGE_MAX : quot[EDGE_W-1:0];
    res.col        = meta_r.col;
    res.row        = meta_r.row;
  end

endmodule

### hw/rtl/sobel_rgb_edge_magnitude_unit.sv
// Top level of the streaming RGB Sobel edge magnitude unit.
// The unit takes one raster-ordered pixel per clock while in_tready is high and keeps up
// with a continuous pixel stream: each item reads both line stores at its column in the
// cycle it is accepted and writes them back in the next cycle, with forwarding when two
// items in a row hit the same column. A result for an interior pixel passes the s1 and s2
// registers and the kernel output register before it enters the output queue; border
// pixels give none. The input side stalls only when the eight-entry output queue together
// with the three items still in the pipeline would fill it, so with the output side ready
// the sustained rate is one item per cycle.
module sobel_rgb_edge_magnitude_unit
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [PIX_W-1:0]  in_tdata,   // chan0, chan1, chan2
  input  logic [0:0]        in_tuser,   // frame_start
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // edge_value, center_column, center_row, zero pad
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  function automatic logic [12:0] clamp_size(input logic [CFG_W-1:0] v, input logic [12:0] hi);
    logic [12:0] v13;
    v13 = {1'b0, v};
    if (v13 < 13'(MIN_SIZE)) begin
      return 13'(MIN_SIZE);
    end else if (v13 > hi) begin
      return hi;
    end
    return v13;
  endfunction

  logic [WW-1:0]           width_r;
  logic [HW-1:0]           height_r;
  logic [CW-1:0]           col_r;
  logic [RW-1:0]           row_r;
  logic                    accept;
  logic [CW-1:0]           c_cur;
  logic [RW-1:0]           r_cur;
  logic [WW:0]             c_p1;
  logic [HW:0]             r_p1;
  sobel_meta_t             meta_cur;

  logic                    s1_valid_r;
  logic [CW-1:0]           s1_addr_r;
  logic [PIX_W-1:0]        s1_px_r;
  sobel_meta_t             s1_meta_r;
  logic                    s2_valid_r;
  sobel_meta_t             s2_meta_r;
  logic [8:0][PIX_W-1:0]   win_r;

  logic [PIX_W-1:0]        up_rd;
  logic [PIX_W-1:0]        mid_rd;
  logic [PIX_W-1:0]        up_eff;
  logic [PIX_W-1:0]        mid_eff;
  logic                    fwd_hit_r;
  logic [PIX_W-1:0]        fwd_up_r;
  logic [PIX_W-1:0]        fwd_mid_r;

  sobel_res_t              kres;
  logic [RES_W-1:0]        fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]      wp_r;
  logic [FIFO_AW-1:0]      rp_r;
  logic [FIFO_CW-1:0]      cnt_r;
  logic [FIFO_CW-1:0]      occ;
  logic                    push;
  logic                    pop;

  assign accept = in_tvalid && in_tready;
  assign c_cur  = in_tuser[0] ? '0 : col_r;
  assign r_cur  = in_tuser[0] ? '0 : row_r;
  assign c_p1   = (WW+1)'(c_cur) + (WW+1)'(1);
  assign r_p1   = (HW+1)'(r_cur) + (HW+1)'(1);

  always_comb begin
    meta_cur.emit = (c_cur >= CW'(2)) && (c_p1 <= {1'b0, width_r})
                 && (r_cur >= RW'(2)) && (r_p1 <= {1'b0, height_r});
    meta_cur.col  = COORD_W'(c_cur - CW'(1));
    meta_cur.row  = COORD_W'(r_cur - RW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(clamp_size(CFG_W'(RESET_WIDTH), 13'(MAX_WIDTH)));
      height_r <= HW'(clamp_size(CFG_W'(RESET_HEIGHT), 13'(MAX_HEIGHT)));
    end else if (cfg_we) begin
      unique case (sobel_cfg_idx_t'(cfg_addr))
        CFG_FRAME_WIDTH:  width_r  <= WW'(clamp_size(cfg_wdata, 13'(MAX_WIDTH)));
        CFG_FRAME_HEIGHT: height_r <= HW'(clamp_size(cfg_wdata, 13'(MAX_HEIGHT)));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (c_p1 >= {1'b0, width_r}) begin
        col_r <= '0;
        row_r <= (r_p1 >= {1'b0, height_r}) ? '0 : RW'(r_p1);
      end else begin
        col_r <= CW'(c_p1);
        row_r <= r_cur;
      end
    end
  end

  sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (mid_eff),
    .raddr (c_cur),
    .rdata (up_rd)
  );

  sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (s1_px_r),
    .raddr (c_cur),
    .rdata (mid_rd)
  );

  assign up_eff  = fwd_hit_r ? fwd_up_r  : up_rd;
  assign mid_eff = fwd_hit_r ? fwd_mid_r : mid_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
      win_r      <= '0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      fwd_hit_r  <= s1_valid_r && (s1_addr_r == c_cur);
      if (s1_valid_r) begin
        for (int k = 0; k < 3; k++) begin
          win_r[3*k]   <= win_r[3*k+1];
          win_r[3*k+1] <= win_r[3*k+2];
        end
        win_r[2] <= up_eff;
        win_r[5] <= mid_eff;
        win_r[8] <= s1_px_r;
      end
    end
    s1_addr_r <= c_cur;
    s1_px_r   <= in_tdata;
    s1_meta_r <= meta_cur;
    s2_meta_r <= s1_meta_r;
    fwd_up_r  <= mid_eff;
    fwd_mid_r <= s1_px_r;
  end

  sobel_kernel u_kernel (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s2_valid_r && s2_meta_r.emit),
    .window   (win_r),
    .meta     (s2_meta_r),
    .res      (kres)
  );

  assign push = kres.valid;
  assign pop  = out_tvalid && out_tready;
  assign occ  = cnt_r + FIFO_CW'(s1_valid_r) + FIFO_CW'(s2_valid_r) + FIFO_CW'(kres.valid);
  assign in_tready = occ < FIFO_CW'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + FIFO_AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + FIFO_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - FIFO_CW'(1);
      end
    end
    if (push) begin
      fifo_r[wp_r] <= {kres.row, kres.col, kres.edge_value};
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = OUT_W'(fifo_r[rp_r]);

endmodule

### hw/rtl/sobel_checker.sv
// Port-level checks for the RGB Sobel edge magnitude unit, bound to the top level.
module sobel_checker
  import sobel_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled output item changed or was dropped.");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:RES_W] == '0)
    else $error("Output padding bits are not zero.");

  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[EDGE_W +: COORD_W] != '0
                && out_tdata[EDGE_W+COORD_W +: COORD_W] != '0)
    else $error("Result reported for a border pixel.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Output valid right after reset.");

endmodule

bind sobel_rgb_edge_magnitude_unit sobel_checker u_sobel_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
